>>> sv/ptt_pkg.sv
// Shared types, codes and the microcode program of the periodic timer table.
`timescale 1ns / 1ps

package ptt_pkg;

    // Defaults for the top-level parameters.
    localparam int SLOTS_DEF     = 3;
    localparam int KEY_WIDTH_DEF = 8;

    // Fixed field widths of the stream items.
    localparam int CMD_W       = 2;
    localparam int KEY_FIELD_W = 8;
    localparam int PERIOD_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = KEY_FIELD_W + PERIOD_W;
    localparam int OUT_DATA_W  = KEY_FIELD_W;
    localparam int OUT_USER_W  = 1 + STATUS_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // Program steps.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_EMIT,
        S_FIND,
        S_STOP,
        S_REPLY
    } step_t;

    // Datapath operations selected by a control word.
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_TICK,
        OP_EMIT,
        OP_FIND,
        OP_STOP,
        OP_REPLY
    } op_t;

    // Jump conditions.
    typedef enum logic {
        C_DONE,
        C_DISPATCH
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        step_t alt;
    } ctl_word_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic             hold;
        logic             done;
        logic [CMD_W-1:0] cmd;
        logic             key_nz;
    } seq_flags_t;

    // Microcode ROM: one control word per step.
    function automatic ctl_word_t ptt_ucode(input step_t step);
        ctl_word_t w;
        unique case (step)
            S_IDLE:  w = '{op: OP_ACCEPT, cond: C_DISPATCH, target: S_IDLE,  alt: S_IDLE};
            S_TICK:  w = '{op: OP_TICK,   cond: C_DONE,     target: S_EMIT,  alt: S_TICK};
            S_EMIT:  w = '{op: OP_EMIT,   cond: C_DONE,     target: S_IDLE,  alt: S_EMIT};
            S_FIND:  w = '{op: OP_FIND,   cond: C_DONE,     target: S_REPLY, alt: S_FIND};
            S_STOP:  w = '{op: OP_STOP,   cond: C_DONE,     target: S_REPLY, alt: S_STOP};
            S_REPLY: w = '{op: OP_REPLY,  cond: C_DONE,     target: S_IDLE,  alt: S_REPLY};
            default: w = '{op: OP_ACCEPT, cond: C_DONE,     target: S_IDLE,  alt: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> sv/ptt_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module ptt_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptt_pkg::seq_flags_t    flags,
    output ptt_pkg::ctl_word_t     ctl
);
    import ptt_pkg::*;

    step_t     step_reg;
    step_t     step_next;
    ctl_word_t word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Next step: hold while stalled, else take the word's jump.
    always_comb
    begin
        word      = ptt_ucode(step_reg);
        step_next = step_reg;
        if (!flags.hold)
        begin
            unique case (word.cond)
                C_DISPATCH:
                begin
                    unique case (flags.cmd)
                        CMD_TICK:  step_next = S_TICK;
                        CMD_START: step_next = flags.key_nz ? S_FIND : S_REPLY;
                        CMD_STOP:  step_next = flags.key_nz ? S_STOP : S_REPLY;
                        default:   step_next = S_REPLY;
                    endcase
                end
                C_DONE:  step_next = flags.done ? word.target : word.alt;
                default: step_next = S_IDLE;
            endcase
        end
    end

    // Control word out.
    always_comb
    begin
        ctl = ptt_ucode(step_reg);
    end

endmodule

>>> sv/periodic_timer_table_unit.sv
// Top level of the periodic timer table: slot storage, datapath and result register.
`timescale 1ns / 1ps

// Channel   Dir  Signals                      Contents
// s_axis    in   tvalid tready tdata tuser    tuser: cmd; tdata: client_key, period_ticks
// m_axis    out  tvalid tready tdata tuser    tuser: fired, status; tdata: fired_key
//                tlast                        tlast: last result of the item
//
// Walk: an item is taken at the accept step, then a microcoded walk visits one slot a cycle
// while no stalled result register holds it. A tick walks every slot to advance the counts,
// then lists the fired keys in slot order; start and stop search the slots for a nonzero key,
// then reply. The single slot read port and the one-slot-a-cycle walk set each walk's length.
// Reset clears every slot at once, so the table is usable straight after reset.
// A stalled result register holds the walk only at the step that must load a result.

module periodic_timer_table_unit #(
    parameter int SLOTS     = ptt_pkg::SLOTS_DEF,
    parameter int KEY_WIDTH = ptt_pkg::KEY_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // client_key [7:0], period_ticks [23:8]
    input  logic [ptt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd [1:0]
    input  logic [ptt_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fired_key [7:0]
    output logic [ptt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // fired [0], status [2:1]
    output logic [ptt_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                            m_axis_tlast
);
    import ptt_pkg::*;

    // Stored key width: the low KEY_WIDTH bits of the key field are kept, at most all 8 of them.
    localparam int KEY_W = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    // Slot storage, all cleared by reset.
    logic [KEY_W-1:0]    slot_key_reg    [SLOTS];
    logic [PERIOD_W-1:0] slot_period_reg [SLOTS];
    logic [PERIOD_W-1:0] slot_count_reg  [SLOTS];

    // Walk state.
    logic [KEY_W-1:0]    key_reg,        key_next;
    logic [PERIOD_W-1:0] period_reg,     period_next;
    logic [IDX_W-1:0]    idx_reg,        idx_next;
    logic [SLOTS-1:0]    fire_mask_reg,  fire_mask_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg,   free_idx_next;
    logic [STATUS_W-1:0] status_reg,     status_next;

    // Result register.
    logic                   out_valid_reg,  out_valid_next;
    logic                   out_fired_reg;
    logic [KEY_FIELD_W-1:0] out_key_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic                   out_last_reg;

    ctl_word_t  ctl;
    seq_flags_t flags;

    // Combinational datapath signals.
    logic [KEY_W-1:0]    in_key;
    logic [KEY_W-1:0]    rd_key;
    logic [PERIOD_W-1:0] rd_period;
    logic [PERIOD_W-1:0] rd_count;
    logic [PERIOD_W-1:0] cnt_inc;
    logic                idx_last;
    logic                rd_match;
    logic                rd_empty;
    logic                rd_active;
    logic                rd_fire;
    logic [SLOTS-1:0]    mask_rem;
    logic                out_free;
    logic                hold;
    logic                done;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [KEY_W-1:0]    wr_key;
    logic [PERIOD_W-1:0] wr_period;
    logic [PERIOD_W-1:0] wr_count;

    logic                   out_load;
    logic                   out_fired;
    logic [KEY_FIELD_W-1:0] out_key;
    logic [STATUS_W-1:0]    out_status;
    logic                   out_last;

    ptt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    assign in_key    = s_axis_tdata[KEY_W-1:0];
    assign rd_key    = slot_key_reg[idx_reg];
    assign rd_period = slot_period_reg[idx_reg];
    assign rd_count  = slot_count_reg[idx_reg];
    assign cnt_inc   = rd_count + 1'b1;
    assign idx_last  = (idx_reg == IDX_LAST);
    assign rd_match  = (rd_key == key_reg);
    assign rd_empty  = (rd_key == '0);
    assign rd_active = !rd_empty && (rd_period != '0);
    assign rd_fire   = rd_active && (cnt_inc == rd_period);
    assign mask_rem  = fire_mask_reg & ~(SLOTS'(1) << idx_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (ctl.op == OP_ACCEPT);

    assign flags = '{hold: hold, done: done, cmd: s_axis_tuser, key_nz: (in_key != '0)};

    // Datapath: tick, emit, find and stop walk one slot per cycle while the result register does not stall.
    always_comb
    begin
        key_next        = key_reg;
        period_next     = period_reg;
        idx_next        = idx_reg;
        fire_mask_next  = fire_mask_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        hold            = 1'b0;
        done            = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_key          = rd_key;
        wr_period       = rd_period;
        wr_count        = rd_count;
        out_load        = 1'b0;
        out_fired       = 1'b0;
        out_key         = '0;
        out_status      = ST_OK;
        out_last        = 1'b1;

        unique case (ctl.op)
            OP_ACCEPT:
            begin
                hold = !s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    key_next        = in_key;
                    period_next     = s_axis_tdata[KEY_FIELD_W +: PERIOD_W];
                    idx_next        = '0;
                    fire_mask_next  = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    status_next     = ST_OK;
                end
            end
            OP_TICK:
            begin
                done = idx_last;
                if (rd_active)
                begin
                    wr_en    = 1'b1;
                    wr_count = rd_fire ? '0 : cnt_inc;
                end
                if (rd_fire)
                begin
                    fire_mask_next[idx_reg] = 1'b1;
                end
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
            end
            OP_EMIT:
            begin
                if (fire_mask_reg == '0)
                begin
                    // Nothing expired: a single empty result.
                    hold     = !out_free;
                    done     = 1'b1;
                    out_load = out_free;
                end
                else if (fire_mask_reg[idx_reg])
                begin
                    hold      = !out_free;
                    done      = (mask_rem == '0);
                    out_load  = out_free;
                    out_fired = 1'b1;
                    out_key   = KEY_FIELD_W'(rd_key);
                    out_last  = (mask_rem == '0);
                    if (out_free)
                    begin
                        fire_mask_next = mask_rem;
                        idx_next       = idx_last ? '0 : idx_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_FIND:
            begin
                if (rd_match)
                begin
                    done      = 1'b1;
                    wr_en     = 1'b1;
                    wr_period = period_reg;
                    wr_count  = '0;
                end
                else if (idx_last)
                begin
                    // No slot holds the key: claim the first empty one.
                    done = 1'b1;
                    if (free_found_reg || rd_empty)
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = free_found_reg ? free_idx_reg : idx_reg;
                        wr_key    = key_reg;
                        wr_period = period_reg;
                        wr_count  = '0;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else
                begin
                    if (rd_empty && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_STOP:
            begin
                if (rd_match)
                begin
                    done      = 1'b1;
                    wr_en     = 1'b1;
                    wr_key    = '0;
                    wr_period = '0;
                    wr_count  = '0;
                end
                else if (idx_last)
                begin
                    done        = 1'b1;
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_REPLY:
            begin
                hold       = !out_free;
                done       = 1'b1;
                out_load   = out_free;
                out_status = status_reg;
            end
            default:
            begin
                hold = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Slot storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_key_reg[i]    <= '0;
                slot_period_reg[i] <= '0;
                slot_count_reg[i]  <= '0;
            end
        end
        else if (wr_en)
        begin
            slot_key_reg[wr_idx]    <= wr_key;
            slot_period_reg[wr_idx] <= wr_period;
            slot_count_reg[wr_idx]  <= wr_count;
        end
    end

    // Walk control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            fire_mask_reg  <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            fire_mask_reg  <= fire_mask_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        period_reg <= period_next;
        if (out_load)
        begin
            out_fired_reg  <= out_fired;
            out_key_reg    <= out_key;
            out_status_reg <= out_status;
            out_last_reg   <= out_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_key_reg;
    assign m_axis_tuser  = {out_status_reg, out_fired_reg};
    assign m_axis_tlast  = out_last_reg;

    // A result is loaded only into a free result register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded over an untaken result");

    // Loading the final result of an item returns the program to the accept step.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last) |=> s_axis_tready)
        else $error("sequencer did not return to accept after last result");

    // All fired slots have been listed before a new item is taken.
    a_mask_drained: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (fire_mask_reg == '0))
        else $error("fired slots left unreported");

    // The walk never leaves the table.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
        else $error("slot index out of range");

endmodule
